// ----- hdl/mstt_pkg.sv -----
// Package for the motor step-test tachometer: types, codes and constants.
`timescale 1ns / 1ps
`default_nettype none
package mstt_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned TicksPerMs = 1000;
  localparam int unsigned DutyCeiling = 100;

  // x / 100 as (x * DivMul) >> DivShift, exact for x below 2^23
  localparam int unsigned DivShift = 30;
  localparam logic [23:0] DivMul = 24'((64'd1 << DivShift) / 100 + 1);

  localparam logic [23:0] RstSamplePeriod = 24'd4000;
  localparam logic [31:0] RstStepPeriod   = 32'd2000000;
  localparam logic [6:0]  RstDutyStep     = 7'd20;
  localparam logic [6:0]  RstDutyMax      = 7'd100;
  localparam logic [15:0] RstRpmPerPulse  = 16'd750;
  localparam logic [15:0] RstPwmTop       = 16'd10000;
  localparam logic [19:0] RstRecordLimit  = 20'd10000;

  typedef enum logic [2:0] {
    REG_SAMPLE_PERIOD = 3'd0,
    REG_STEP_PERIOD   = 3'd1,
    REG_DUTY_STEP     = 3'd2,
    REG_DUTY_MAX      = 3'd3,
    REG_RPM_PER_PULSE = 3'd4,
    REG_PWM_TOP       = 3'd5,
    REG_RECORD_LIMIT  = 3'd6
  } mstt_reg_e;

  typedef enum logic [1:0] {
    EVT_SAMPLE = 2'd0,
    EVT_DUTY   = 2'd1,
    EVT_FINISH = 2'd2
  } mstt_event_e;

  typedef struct packed {
    logic [23:0] sample_period;
    logic [31:0] step_period;
    logic [6:0]  duty_step;
    logic [6:0]  duty_max;
    logic [15:0] rpm_per_pulse;
    logic [15:0] pwm_top;
    logic [19:0] record_limit;
  } mstt_cfg_t;

  // everything one tick produced: an optional record and an optional step
  typedef struct packed {
    logic        rec_v;
    logic        step_v;
    logic        fin;
    logic [15:0] pulses;
    logic [6:0]  rec_duty;
    logic [6:0]  step_duty;
    logic [23:0] ms;
  } mstt_entry_t;

endpackage
`default_nettype wire

// ----- hdl/mstt_front.sv -----
// Tick front end: edge counting, timers, duty ramp and event classification.
`timescale 1ns / 1ps
`default_nettype none
module mstt_front
  import mstt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire mstt_cfg_t   cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        encoder_level_i,
  input  wire logic        full_i,
  output logic             push_o,
  output mstt_entry_t      entry_o
);

  logic        prev_q, prev_d;
  logic [15:0] pulses_q, pulses_d;
  logic [9:0]  sub_ms_q, sub_ms_d;
  logic [23:0] ms_q, ms_d;
  logic [23:0] smp_tmr_q, smp_tmr_d;
  logic [31:0] stp_tmr_q, stp_tmr_d;
  logic [6:0]  duty_q, duty_d;
  logic        ramp_down_q, ramp_down_d;
  logic [19:0] records_q, records_d;
  logic        finished_q, finished_d;

  logic              accept;
  logic              rec, stp;
  logic [15:0]       pulses_inc;
  logic [23:0]       smp_inc;
  logic [31:0]       stp_inc;
  logic [6:0]        ceil_duty;
  logic signed [8:0] nxt;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o && !finished_q;

  always_comb begin
    prev_d      = prev_q;
    pulses_d    = pulses_q;
    sub_ms_d    = sub_ms_q;
    ms_d        = ms_q;
    smp_tmr_d   = smp_tmr_q;
    stp_tmr_d   = stp_tmr_q;
    duty_d      = duty_q;
    ramp_down_d = ramp_down_q;
    records_d   = records_q;
    finished_d  = finished_q;

    pulses_inc = pulses_q;
    if (!prev_q && encoder_level_i && pulses_q != 16'hFFFF) begin
      pulses_inc = pulses_q + 16'd1;
    end
    smp_inc = (smp_tmr_q != 24'hFFFFFF) ? smp_tmr_q + 24'd1 : smp_tmr_q;
    stp_inc = (stp_tmr_q != 32'hFFFFFFFF) ? stp_tmr_q + 32'd1 : stp_tmr_q;

    rec = (smp_inc >= cfg_i.sample_period) && (records_q < cfg_i.record_limit);
    stp = stp_inc >= cfg_i.step_period;

    ceil_duty = (cfg_i.duty_max > 7'(DutyCeiling)) ? 7'(DutyCeiling) : cfg_i.duty_max;
    if (ramp_down_q) begin
      nxt = $signed({2'b00, duty_q}) - $signed({2'b00, cfg_i.duty_step});
    end else begin
      nxt = $signed({2'b00, duty_q}) + $signed({2'b00, cfg_i.duty_step});
    end

    entry_o.rec_v     = rec;
    entry_o.step_v    = stp;
    entry_o.fin       = 1'b0;
    entry_o.pulses    = pulses_inc;
    entry_o.rec_duty  = duty_q;
    entry_o.step_duty = nxt[6:0];
    entry_o.ms        = ms_q;

    if (accept) begin
      prev_d   = encoder_level_i;
      pulses_d = pulses_inc;
      if (sub_ms_q + 10'd1 >= 10'(TicksPerMs)) begin
        sub_ms_d = '0;
        if (ms_q != 24'hFFFFFF) begin
          ms_d = ms_q + 24'd1;
        end
      end else begin
        sub_ms_d = sub_ms_q + 10'd1;
      end
      smp_tmr_d = smp_inc;
      stp_tmr_d = stp_inc;
      if (rec) begin
        records_d = records_q + 20'd1;
        pulses_d  = '0;
        smp_tmr_d = '0;
      end
      if (stp) begin
        stp_tmr_d = '0;
        if (nxt > $signed({2'b00, ceil_duty})) begin
          duty_d      = ceil_duty;
          ramp_down_d = 1'b1;
        end else if (nxt < 0) begin
          duty_d     = '0;
          finished_d = 1'b1;
        end else begin
          duty_d = nxt[6:0];
        end
      end
    end
    entry_o.ms = ms_d;
    if (stp) begin
      entry_o.fin       = finished_d;
      entry_o.step_duty = duty_d;
    end
  end

  assign push_o = accept && (rec || stp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 1'b1;
      pulses_q    <= '0;
      sub_ms_q    <= '0;
      ms_q        <= '0;
      smp_tmr_q   <= '0;
      stp_tmr_q   <= '0;
      duty_q      <= '0;
      ramp_down_q <= 1'b0;
      records_q   <= '0;
      finished_q  <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      pulses_q    <= pulses_d;
      sub_ms_q    <= sub_ms_d;
      ms_q        <= ms_d;
      smp_tmr_q   <= smp_tmr_d;
      stp_tmr_q   <= stp_tmr_d;
      duty_q      <= duty_d;
      ramp_down_q <= ramp_down_d;
      records_q   <= records_d;
      finished_q  <= finished_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mstt_fifo.sv -----
// Short queue of per-tick event bundles between front and back.
`timescale 1ns / 1ps
`default_nettype none
module mstt_fifo
  import mstt_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire mstt_entry_t wdata_i,
  input  wire logic        pop_i,
  output mstt_entry_t      rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  mstt_entry_t   mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mstt_back.sv -----
// Back end: splits bundles into results, scales rpm and PWM level, output register.
`timescale 1ns / 1ps
`default_nettype none
module mstt_back
  import mstt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire mstt_cfg_t   cfg_i,
  input  wire mstt_entry_t entry_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       event_type_o,
  output logic [23:0]      elapsed_ms_o,
  output logic [6:0]       duty_percent_o,
  output logic [15:0]      pwm_level_o,
  output logic [31:0]      rpm_o,
  output logic             last_o
);

  logic        half_q;
  logic        a_v_q;
  mstt_event_e a_evt_q;
  logic [23:0] a_ms_q;
  logic [6:0]  a_duty_q;
  logic [22:0] a_prod_q;
  logic [31:0] a_rpm_q;
  logic        a_last_q;

  logic        o_v_q;
  mstt_event_e o_evt_q;
  logic [23:0] o_ms_q;
  logic [6:0]  o_duty_q;
  logic [15:0] o_pwm_q;
  logic [31:0] o_rpm_q;
  logic        o_last_q;

  logic        o_load, a_load, issue, take_rec;
  mstt_event_e i_evt;
  logic [6:0]  i_duty;
  logic [46:0] quot_full;

  assign o_load = !o_v_q || out_ready_i;
  assign a_load = !a_v_q || o_load;
  assign issue  = a_load && !empty_i;

  assign take_rec = entry_i.rec_v && !half_q;
  assign pop_o    = issue && !(take_rec && entry_i.step_v);

  always_comb begin
    if (take_rec) begin
      i_evt  = EVT_SAMPLE;
      i_duty = entry_i.rec_duty;
    end else if (entry_i.fin) begin
      i_evt  = EVT_FINISH;
      i_duty = '0;
    end else begin
      i_evt  = EVT_DUTY;
      i_duty = entry_i.step_duty;
    end
  end

  assign quot_full = {24'd0, a_prod_q} * {23'd0, DivMul};

  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_evt_q  <= i_evt;
      a_ms_q   <= entry_i.ms;
      a_duty_q <= i_duty;
      a_last_q <= !(take_rec && entry_i.step_v);
      a_prod_q <= (i_evt == EVT_DUTY) ? 23'(cfg_i.pwm_top) * 23'(i_duty) : '0;
      a_rpm_q  <= take_rec ? 32'(entry_i.pulses) * 32'(cfg_i.rpm_per_pulse) : '0;
    end
    if (o_load && a_v_q) begin
      o_evt_q  <= a_evt_q;
      o_ms_q   <= a_ms_q;
      o_duty_q <= a_duty_q;
      o_pwm_q  <= quot_full[DivShift +: 16];
      o_rpm_q  <= a_rpm_q;
      o_last_q <= a_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 1'b0;
      a_v_q  <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (issue) begin
        half_q <= take_rec && entry_i.step_v;
      end
      if (a_load) begin
        a_v_q <= issue;
      end
      if (o_load) begin
        o_v_q <= a_v_q;
      end
    end
  end

  assign out_valid_o    = o_v_q;
  assign event_type_o   = o_evt_q;
  assign elapsed_ms_o   = o_ms_q;
  assign duty_percent_o = o_duty_q;
  assign pwm_level_o    = o_pwm_q;
  assign rpm_o          = o_rpm_q;
  assign last_o         = o_last_q;

endmodule
`default_nettype wire

// ----- hdl/motor_step_test_tachometer_core.sv -----
// Top level of the motor step-test tachometer: registers, front, queue, back.
`timescale 1ns / 1ps
`default_nettype none
// One input transaction is one 1 us tick carrying the encoder level; a tick is
// accepted every cycle while the event queue between the tick front end and the
// result back end has room (QueueDepth bundles). A tick yields zero, one or two
// results; the back end delivers one result per cycle while out_ready_i is high,
// through a two-stage pipeline (products, then the divide by 100 as a reciprocal
// multiply). After the finish result, ticks are still accepted and ignored until
// reset. Registers are written through cfg_we_i/cfg_index_i/cfg_wdata_i only
// while the block is idle: a rule for the user, not enforced by the block.
module motor_step_test_tachometer_core
  import mstt_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        encoder_level_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       event_type_o,
  output logic [23:0]      elapsed_ms_o,
  output logic [6:0]       duty_percent_o,
  output logic [15:0]      pwm_level_o,
  output logic [31:0]      rpm_o,
  output logic             last_o
);

  mstt_cfg_t   cfg_q;
  mstt_entry_t push_entry, head_entry;
  logic        push, pop, q_empty, q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_period <= RstSamplePeriod;
      cfg_q.step_period   <= RstStepPeriod;
      cfg_q.duty_step     <= RstDutyStep;
      cfg_q.duty_max      <= RstDutyMax;
      cfg_q.rpm_per_pulse <= RstRpmPerPulse;
      cfg_q.pwm_top       <= RstPwmTop;
      cfg_q.record_limit  <= RstRecordLimit;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_wdata_i[23:0];
        REG_STEP_PERIOD:   cfg_q.step_period   <= cfg_wdata_i;
        REG_DUTY_STEP:     cfg_q.duty_step     <= cfg_wdata_i[6:0];
        REG_DUTY_MAX:      cfg_q.duty_max      <= cfg_wdata_i[6:0];
        REG_RPM_PER_PULSE: cfg_q.rpm_per_pulse <= cfg_wdata_i[15:0];
        REG_PWM_TOP:       cfg_q.pwm_top       <= cfg_wdata_i[15:0];
        REG_RECORD_LIMIT:  cfg_q.record_limit  <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  mstt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .encoder_level_i (encoder_level_i),
    .full_i          (q_full),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  mstt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  mstt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .entry_i        (head_entry),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_type_o   (event_type_o),
    .elapsed_ms_o   (elapsed_ms_o),
    .duty_percent_o (duty_percent_o),
    .pwm_level_o    (pwm_level_o),
    .rpm_o          (rpm_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire

// ----- dv/tacho_check_pkg.sv -----
// Scoreboard for the tachometer bench: tick predictor, pending results and mismatch reporting.
`timescale 1ns / 1ps
package tacho_check_pkg;
  import mstt_pkg::*;

  typedef struct packed {
    mstt_event_e kind;
    logic [23:0] ms;
    logic [6:0]  duty;
    logic [15:0] level;
    logic [31:0] rpm;
    logic        last;
  } tacho_result_t;

  class tacho_scoreboard;
    logic [23:0] cfg_sample_period;
    logic [31:0] cfg_step_period;
    logic [6:0]  cfg_duty_step;
    logic [6:0]  cfg_duty_max;
    logic [15:0] cfg_rpm_per_pulse;
    logic [15:0] cfg_pwm_top;
    logic [19:0] cfg_record_limit;

    logic        prev_level;
    logic [15:0] pulse_count;
    logic [9:0]  sub_ms;
    logic [23:0] ms_count;
    logic [23:0] sample_timer;
    logic [31:0] step_timer;
    logic [6:0]  duty_now;
    logic        ramp_down;
    logic [19:0] records_sent;
    logic        finished;

    tacho_result_t pending_results[$];
    int unsigned   errors;
    int unsigned   results_seen;

    function new();
      cfg_sample_period = RstSamplePeriod;
      cfg_step_period   = RstStepPeriod;
      cfg_duty_step     = RstDutyStep;
      cfg_duty_max      = RstDutyMax;
      cfg_rpm_per_pulse = RstRpmPerPulse;
      cfg_pwm_top       = RstPwmTop;
      cfg_record_limit  = RstRecordLimit;
      prev_level   = 1'b1;
      pulse_count  = '0;
      sub_ms       = '0;
      ms_count     = '0;
      sample_timer = '0;
      step_timer   = '0;
      duty_now     = '0;
      ramp_down    = 1'b0;
      records_sent = '0;
      finished     = 1'b0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_SAMPLE_PERIOD: cfg_sample_period = val[23:0];
        REG_STEP_PERIOD:   cfg_step_period   = val;
        REG_DUTY_STEP:     cfg_duty_step     = val[6:0];
        REG_DUTY_MAX:      cfg_duty_max      = val[6:0];
        REG_RPM_PER_PULSE: cfg_rpm_per_pulse = val[15:0];
        REG_PWM_TOP:       cfg_pwm_top       = val[15:0];
        REG_RECORD_LIMIT:  cfg_record_limit  = val[19:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void push_result(mstt_event_e kind, logic [6:0] duty, logic [15:0] level,
                              logic [31:0] rpm);
      tacho_result_t r;
      r.kind  = kind;
      r.ms    = ms_count;
      r.duty  = duty;
      r.level = level;
      r.rpm   = rpm;
      r.last  = 1'b0;
      pending_results.push_back(r);
    endfunction

    // Advance the tachometer by one accepted tick and queue what it emits.
    function void predict_tick(logic level);
      int unsigned first;
      int          ceiling;
      int          next_duty;
      logic [31:0] scaled;
      if (finished) return;
      first = pending_results.size();

      if (!prev_level && level && pulse_count != 16'hFFFF) pulse_count++;
      prev_level = level;

      if (sub_ms == 10'(TicksPerMs - 1)) begin
        sub_ms = '0;
        if (ms_count != 24'hFFFFFF) ms_count++;
      end else begin
        sub_ms++;
      end
      if (sample_timer != 24'hFFFFFF) sample_timer++;
      if (step_timer != 32'hFFFFFFFF) step_timer++;

      if (sample_timer >= cfg_sample_period && records_sent < cfg_record_limit) begin
        push_result(EVT_SAMPLE, duty_now, 16'd0, 32'(pulse_count) * 32'(cfg_rpm_per_pulse));
        records_sent++;
        pulse_count  = '0;
        sample_timer = '0;
      end

      if (step_timer >= cfg_step_period) begin
        ceiling   = (cfg_duty_max > DutyCeiling) ? DutyCeiling : int'(cfg_duty_max);
        next_duty = ramp_down ? int'(duty_now) - int'(cfg_duty_step)
                              : int'(duty_now) + int'(cfg_duty_step);
        step_timer = '0;
        if (next_duty > ceiling) begin
          next_duty = ceiling;
          ramp_down = 1'b1;
        end
        if (next_duty < 0) begin
          finished = 1'b1;
          duty_now = '0;
          push_result(EVT_FINISH, 7'd0, 16'd0, 32'd0);
        end else begin
          duty_now = 7'(next_duty);
          scaled   = (32'(cfg_pwm_top) * 32'(duty_now)) / 32'(DutyCeiling);
          push_result(EVT_DUTY, duty_now, scaled[15:0], 32'd0);
        end
      end

      if (pending_results.size() > first)
        pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    task report(string what, longint unsigned got_v, longint unsigned want_v);
      if (errors < 50)
        $display("%0t mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
                 $time, results_seen, what, got_v, want_v);
      errors++;
    endtask

    task check_result(tacho_result_t got);
      tacho_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report("result with nothing pending, event_type", got.kind, 0);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind != want.kind)   report("event_type", got.kind, want.kind);
      if (got.ms != want.ms)       report("elapsed_ms", got.ms, want.ms);
      if (got.duty != want.duty)   report("duty_percent", got.duty, want.duty);
      if (got.level != want.level) report("pwm_level", got.level, want.level);
      if (got.rpm != want.rpm)     report("rpm", got.rpm, want.rpm);
      if (got.last != want.last)   report("last", got.last, want.last);
    endtask
  endclass

endpackage

// ----- dv/tb_top.sv -----
// Top-level bench for the motor step-test tachometer core: stimulus, handshakes, watchdog.
`timescale 1ns / 1ps
module tb_top;
  import mstt_pkg::*;
  import tacho_check_pkg::*;

  localparam logic [2:0] RegNone = 3'd7;
  localparam int SettleCycles = QueueDepthDefault + 6;
  localparam int HoldOffCycles = 300;
  localparam int StallLimit = 2000;
  localparam int RandomPhases = 14;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        encoder_level_i = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  event_type_o;
  logic [23:0] elapsed_ms_o;
  logic [6:0]  duty_percent_o;
  logic [15:0] pwm_level_o;
  logic [31:0] rpm_o;
  logic        last_o;

  tacho_scoreboard sb = new();
  bit idle_en = 1'b1;
  bit hold_off_request = 1'b0;
  logic tick_level = 1'b0;
  int unsigned stall_cycles = 0;

  motor_step_test_tachometer_core dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .encoder_level_i,
    .out_valid_o,
    .out_ready_i,
    .event_type_o,
    .elapsed_ms_o,
    .duty_percent_o,
    .pwm_level_o,
    .rpm_o,
    .last_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result('{kind: mstt_event_e'(event_type_o), ms: elapsed_ms_o,
                        duty: duty_percent_o, level: pwm_level_o, rpm: rpm_o,
                        last: last_o});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("FAIL motor_step_test_tachometer_core");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= !idle_en || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_tick(logic level);
    while (idle_en && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    encoder_level_i <= level;
    do @(posedge clk_i); while (!in_ready_o);
    sb.predict_tick(level);
    tick_level = level;
  endtask

  task automatic wait_results_done();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic drain();
    wait_results_done();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_levels(logic [15:0] bits, int n);
    for (int i = 0; i < n; i++) send_tick(bits[i]);
    in_valid_i <= 1'b0;
    drain();
  endtask

  task automatic run_ticks(int n, int toggle_pct, int pause_at);
    logic level;
    level = tick_level;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) begin
        in_valid_i <= 1'b0;
        wait_results_done();
      end
      if ($urandom_range(0, 99) < toggle_pct) level = ~level;
      send_tick(level);
    end
    in_valid_i <= 1'b0;
    drain();
  endtask

  // Random settings for one phase; the duty step is capped so the ramp cannot
  // fall below zero before the closing phase.
  task automatic random_config(int n, bit dense);
    logic [31:0] sample_p;
    logic [31:0] step_p;
    logic [31:0] limit;
    logic [6:0]  dmax;
    int          ceil_pct;
    int          bound;
    int          steps;
    int          step_cap;
    case ($urandom_range(0, 7))
      0:       sample_p = 32'd0;
      1:       sample_p = 32'h00FF_FFFF;
      2:       sample_p = $urandom;
      default: sample_p = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 7))
      0:       step_p = 32'd0;
      1:       step_p = 32'hFFFF_FFFF;
      default: step_p = $urandom_range(1, 60);
    endcase
    if (dense) begin
      sample_p = 32'd0;
      step_p   = 32'd0;
    end
    steps = (step_p == 0) ? n : int'(longint'(n) / longint'(step_p)) + 2;
    dmax = ($urandom_range(0, 3) == 0) ? 7'd100 : 7'($urandom_range(0, 127));
    ceil_pct = (dmax > DutyCeiling) ? DutyCeiling : int'(dmax);
    bound = ceil_pct;
    if (sb.ramp_down && int'(sb.duty_now) < bound) bound = int'(sb.duty_now);
    step_cap = bound / steps;
    if (step_cap > 127) step_cap = 127;
    case ($urandom_range(0, 3))
      0:       limit = 32'(sb.records_sent) + $urandom_range(0, 20);
      1:       limit = 32'd0;
      default: limit = 32'hFFFF_FFFF;
    endcase
    write_reg(REG_SAMPLE_PERIOD, sample_p);
    write_reg(REG_STEP_PERIOD, step_p);
    write_reg(REG_DUTY_STEP, 32'($urandom_range(0, step_cap)));
    write_reg(REG_DUTY_MAX, 32'(dmax));
    write_reg(REG_RPM_PER_PULSE, $urandom);
    write_reg(REG_PWM_TOP, $urandom);
    write_reg(REG_RECORD_LIMIT, limit);
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every tick samples and steps; zero duty step, ceiling above 100,
    // widest registers, record limit hit after three records
    write_reg(REG_SAMPLE_PERIOD, 32'd0);
    write_reg(REG_STEP_PERIOD, 32'd0);
    write_reg(REG_DUTY_STEP, 32'd0);
    write_reg(REG_DUTY_MAX, 32'hFFFF_FFFF);
    write_reg(REG_RPM_PER_PULSE, 32'hFFFF_FFFF);
    write_reg(REG_PWM_TOP, 32'hFFFF_FFFF);
    write_reg(REG_RECORD_LIMIT, 32'd3);
    write_reg(RegNone, 32'hFFFF_FFFF);
    send_levels(16'b111010, 6);

    // ramp lands exactly on the ceiling without turning
    write_reg(REG_DUTY_STEP, 32'd100);
    write_reg(REG_DUTY_MAX, 32'd100);
    write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_RECORD_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_RPM_PER_PULSE, 32'd1);
    write_reg(REG_PWM_TOP, 32'd1);
    send_levels(16'b1, 1);

    // ceiling below the duty while ramping up: clamp and turn down
    write_reg(REG_DUTY_MAX, 32'd90);
    write_reg(REG_DUTY_STEP, 32'd5);
    write_reg(REG_PWM_TOP, 32'd0);
    send_levels(16'b0, 1);

    // ceiling below the duty while ramping down, zero step
    write_reg(REG_DUTY_MAX, 32'd85);
    write_reg(REG_DUTY_STEP, 32'd0);
    write_reg(REG_PWM_TOP, 32'd12345);
    send_levels(16'b01, 2);

    write_reg(REG_DUTY_STEP, 32'd1);
    write_reg(REG_STEP_PERIOD, 32'd1);
    write_reg(REG_SAMPLE_PERIOD, 32'd1);
    write_reg(REG_RPM_PER_PULSE, 32'd750);
    send_levels(16'b0101, 4);

    // no records allowed: the pulse count keeps running
    idle_en = 1'b0;
    write_reg(REG_RECORD_LIMIT, 32'd0);
    write_reg(REG_STEP_PERIOD, 32'hFFFF_FFFF);
    run_ticks(40, 100, -1);
    write_reg(REG_SAMPLE_PERIOD, 32'd1);
    write_reg(REG_RECORD_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_RPM_PER_PULSE, 32'hFFFF_FFFF);
    run_ticks(3, 50, -1);
    idle_en = 1'b1;

    for (int p = 0; p < RandomPhases; p++) begin
      n = $urandom_range(60, 140);
      idle_en = !(p == 2 || p == 3);
      random_config(n, p == 2);
      if (p == 2) hold_off_request = 1'b1;
      run_ticks(n, $urandom_range(5, 95), (p == 6) ? n / 2 : -1);
    end
    idle_en = 1'b1;

    // closing phase: the ramp drops below zero, later ticks are ignored
    write_reg(REG_SAMPLE_PERIOD, 32'd0);
    write_reg(REG_STEP_PERIOD, 32'd0);
    write_reg(REG_DUTY_STEP, 32'd100);
    write_reg(REG_DUTY_MAX, 32'd100);
    write_reg(REG_RECORD_LIMIT, 32'hFFFF_FFFF);
    run_ticks(24, 50, -1);

    if (sb.errors == 0) begin
      $display("PASS motor_step_test_tachometer_core");
    end else begin
      $display("FAIL motor_step_test_tachometer_core");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mstt_pkg.sv
hdl/mstt_front.sv
hdl/mstt_fifo.sv
hdl/mstt_back.sv
hdl/motor_step_test_tachometer_core.sv
dv/tacho_check_pkg.sv
dv/tb_top.sv
